/* design/periodic_timer_pool_assert.svh */
// ----------------------------------------------------------------------------
// Periodic timer pool assertion macros
// Clocked, reset-qualified property shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_POOL_ASSERT_SVH
`define PERIODIC_TIMER_POOL_ASSERT_SVH

// Check an expression at every clock edge outside reset.
`define PTP_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies another one in the following cycle.
`define PTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ptp_pkg.sv */
// ----------------------------------------------------------------------------
// Periodic timer pool package
// Command and result codes, widths and the slot store write controls.
// ----------------------------------------------------------------------------
package ptp_pkg;

    localparam int NUM_SLOTS_DEF = 8;
    localparam int MAX_RESULTS   = 8;
    localparam int FIRE_W        = $clog2(MAX_RESULTS + 1);
    localparam int CMD_W         = 2;
    localparam int KIND_W        = 2;
    localparam int SLOT_W        = 3;
    localparam int CNT16_W       = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CREATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_KILL   = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_FIRED   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CREATED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FAILED  = 2'd2;

    // Write controls from the sequencer to the slot store
    typedef struct packed {
        logic el_we;
        logic per_we;
        logic vld_set;
        logic vld_clr;
    } store_wr_t;

endpackage

/* design/ptp_alu.sv */
// ----------------------------------------------------------------------------
// Periodic timer pool slot unit
// Saturating add of the tick delta to one slot's elapsed count and the
// compare against its period; shared by every slot of a scan.
// ----------------------------------------------------------------------------
module ptp_alu
(
    input  logic [ptp_pkg::CNT16_W-1:0] elapsed,
    input  logic [ptp_pkg::CNT16_W-1:0] delta,
    input  logic [ptp_pkg::CNT16_W-1:0] period,
    output logic [ptp_pkg::CNT16_W-1:0] sum_sat,
    output logic                        reached
);

    logic [ptp_pkg::CNT16_W:0] sum_full;

    // Add with carry, clamp on overflow
    assign sum_full = {1'b0, elapsed} + {1'b0, delta};
    assign sum_sat  = sum_full[ptp_pkg::CNT16_W] ? {ptp_pkg::CNT16_W{1'b1}}
                                                 : sum_full[ptp_pkg::CNT16_W-1:0];

    // Fire when the new count meets the period
    assign reached = (sum_sat >= period);

endmodule

/* design/ptp_store.sv */
// ----------------------------------------------------------------------------
// Periodic timer pool slot store
// Period and elapsed memories with one read port (registered data) and
// per-slot valid bits; an invalid slot reads as period zero, elapsed zero.
// ----------------------------------------------------------------------------
module ptp_store #(
    parameter int NUM_SLOTS = ptp_pkg::NUM_SLOTS_DEF,
    parameter int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [IDX_W-1:0]            rd_addr,
    input  ptp_pkg::store_wr_t          wr,
    input  logic [IDX_W-1:0]            wr_addr,
    input  logic [IDX_W-1:0]            clr_addr,
    input  logic [ptp_pkg::CNT16_W-1:0] el_wdata,
    input  logic [ptp_pkg::CNT16_W-1:0] per_wdata,
    output logic [ptp_pkg::CNT16_W-1:0] rd_period,
    output logic [ptp_pkg::CNT16_W-1:0] rd_elapsed
);

    logic [ptp_pkg::CNT16_W-1:0] period_mem  [NUM_SLOTS];
    logic [ptp_pkg::CNT16_W-1:0] elapsed_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]        valid_reg;
    logic [NUM_SLOTS-1:0]        valid_next;
    logic [ptp_pkg::CNT16_W-1:0] rd_period_reg;
    logic [ptp_pkg::CNT16_W-1:0] rd_elapsed_reg;

    // Set on create, drop on kill
    always_comb
    begin
        valid_next = valid_reg;
        if (wr.vld_set)
        begin
            valid_next[wr_addr] = 1'b1;
        end
        if (wr.vld_clr)
        begin
            valid_next[clr_addr] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Write the memories and register the read port
    always_ff @(posedge clk)
    begin
        if (wr.per_we)
        begin
            period_mem[wr_addr] <= per_wdata;
        end
        if (wr.el_we)
        begin
            elapsed_mem[wr_addr] <= el_wdata;
        end
        rd_period_reg  <= valid_reg[rd_addr] ? period_mem[rd_addr]  : '0;
        rd_elapsed_reg <= valid_reg[rd_addr] ? elapsed_mem[rd_addr] : '0;
    end

    assign rd_period  = rd_period_reg;
    assign rd_elapsed = rd_elapsed_reg;

endmodule

/* design/periodic_timer_pool.sv */
// Tick: busy after the accepting edge through the scan and the done state, one slot per cycle
// through the shared add/compare unit and the single store read port.
// Fire results appear during the scan; the marked last one is issued from the done state.
// Create: busy until a free slot is claimed or the last slot fails, one result. Kill,
// unchanged tick and unused codes stay idle with no result. Results cannot be stalled.
// Reset clears the tick history and frees every slot at once; no clearing pass.
// ----------------------------------------------------------------------------
// Periodic timer pool
// Pool of periodic timer slots: create, kill and tick commands with a
// sequencer that walks the slots through one shared arithmetic unit.
// ----------------------------------------------------------------------------
`include "periodic_timer_pool_assert.svh"

module periodic_timer_pool #(
    parameter int NUM_SLOTS = ptp_pkg::NUM_SLOTS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ptp_pkg::CMD_W-1:0]   cmd,
    input  logic [ptp_pkg::CNT16_W-1:0] tick_count,
    input  logic [ptp_pkg::CNT16_W-1:0] interval,
    input  logic [ptp_pkg::SLOT_W-1:0]  slot,
    output logic                        result_strobe,
    output logic [ptp_pkg::KIND_W-1:0]  kind,
    output logic [ptp_pkg::SLOT_W-1:0]  slot_index,
    output logic                        last
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE,
        ST_FIND
    } state_t;

    state_t                        state_reg, state_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [ptp_pkg::CNT16_W-1:0]   last_tick_reg, last_tick_next;
    logic [ptp_pkg::CNT16_W-1:0]   diff_reg, diff_next;
    logic [ptp_pkg::CNT16_W-1:0]   ivl_reg, ivl_next;
    logic                          pend_vld_reg, pend_vld_next;
    logic [ptp_pkg::SLOT_W-1:0]    pend_idx_reg, pend_idx_next;
    logic [ptp_pkg::FIRE_W-1:0]    fire_cnt_reg, fire_cnt_next;
    logic                          strobe_reg, strobe_next;
    logic [ptp_pkg::KIND_W-1:0]    kind_reg, kind_next;
    logic [ptp_pkg::SLOT_W-1:0]    slot_index_reg, slot_index_next;
    logic                          last_reg, last_next;

    logic                          accept;
    logic [CNT_W-1:0]              rd_nxt;
    logic [IDX_W-1:0]              cur_idx;
    logic                          at_end;
    logic [IDX_W-1:0]              rd_addr;
    ptp_pkg::store_wr_t            wr;
    logic [IDX_W-1:0]              clr_addr;
    logic [ptp_pkg::CNT16_W-1:0]   el_wdata;
    logic [ptp_pkg::CNT16_W-1:0]   rd_period;
    logic [ptp_pkg::CNT16_W-1:0]   rd_elapsed;
    logic [ptp_pkg::CNT16_W-1:0]   sum_sat;
    logic                          reached;

    assign accept   = start && (state_reg == ST_IDLE);
    assign busy     = (state_reg != ST_IDLE);
    assign cur_idx  = cnt_reg[IDX_W-1:0];
    assign rd_nxt   = cnt_reg + 1'b1;
    assign at_end   = (cnt_reg == CNT_W'(NUM_SLOTS - 1));
    assign clr_addr = IDX_W'(slot);

    // Read slot 0 while idle, else prefetch the slot after the current one
    assign rd_addr = (state_reg == ST_IDLE) ? '0 :
                     (rd_nxt < CNT_W'(NUM_SLOTS)) ? rd_nxt[IDX_W-1:0] : '0;

    ptp_store #(
        .NUM_SLOTS (NUM_SLOTS),
        .IDX_W     (IDX_W)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_addr    (rd_addr),
        .wr         (wr),
        .wr_addr    (cur_idx),
        .clr_addr   (clr_addr),
        .el_wdata   (el_wdata),
        .per_wdata  (ivl_reg),
        .rd_period  (rd_period),
        .rd_elapsed (rd_elapsed)
    );

    ptp_alu u_alu (
        .elapsed (rd_elapsed),
        .delta   (diff_reg),
        .period  (rd_period),
        .sum_sat (sum_sat),
        .reached (reached)
    );

    // Sequencer next-state and result logic
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        last_tick_next  = last_tick_reg;
        diff_next       = diff_reg;
        ivl_next        = ivl_reg;
        pend_vld_next   = pend_vld_reg;
        pend_idx_next   = pend_idx_reg;
        fire_cnt_next   = fire_cnt_reg;
        strobe_next     = 1'b0;
        kind_next       = kind_reg;
        slot_index_next = slot_index_reg;
        last_next       = last_reg;
        wr              = '0;
        el_wdata        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        ptp_pkg::CMD_TICK:
                        begin
                            if (tick_count != last_tick_reg)
                            begin
                                last_tick_next = tick_count;
                                diff_next      = tick_count - last_tick_reg;
                                cnt_next       = '0;
                                fire_cnt_next  = '0;
                                pend_vld_next  = 1'b0;
                                state_next     = ST_SCAN;
                            end
                        end
                        ptp_pkg::CMD_CREATE:
                        begin
                            ivl_next   = interval;
                            cnt_next   = '0;
                            state_next = ST_FIND;
                        end
                        ptp_pkg::CMD_KILL:
                        begin
                            wr.vld_clr = (int'(slot) < NUM_SLOTS);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // Advance the active slot, clear it on a fire
                if (rd_period != '0)
                begin
                    wr.el_we = 1'b1;
                    el_wdata = reached ? '0 : sum_sat;
                    if (reached && (fire_cnt_reg < ptp_pkg::FIRE_W'(ptp_pkg::MAX_RESULTS)))
                    begin
                        // Hold the newest fire back until we know whether it is last
                        if (pend_vld_reg)
                        begin
                            strobe_next     = 1'b1;
                            kind_next       = ptp_pkg::KIND_FIRED;
                            slot_index_next = pend_idx_reg;
                            last_next       = 1'b0;
                        end
                        pend_vld_next = 1'b1;
                        pend_idx_next = ptp_pkg::SLOT_W'(cur_idx);
                        fire_cnt_next = fire_cnt_reg + 1'b1;
                    end
                end
                if (at_end)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = rd_nxt;
                end
            end

            ST_DONE:
            begin
                // Release the held fire as the final result
                if (pend_vld_reg)
                begin
                    strobe_next     = 1'b1;
                    kind_next       = ptp_pkg::KIND_FIRED;
                    slot_index_next = pend_idx_reg;
                    last_next       = 1'b1;
                end
                pend_vld_next = 1'b0;
                state_next    = ST_IDLE;
            end

            ST_FIND:
            begin
                // Claim the lowest free slot, or fail after the last one
                if (rd_period == '0)
                begin
                    wr.el_we        = 1'b1;
                    wr.per_we       = 1'b1;
                    wr.vld_set      = 1'b1;
                    el_wdata        = '0;
                    strobe_next     = 1'b1;
                    kind_next       = ptp_pkg::KIND_CREATED;
                    slot_index_next = ptp_pkg::SLOT_W'(cur_idx);
                    last_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
                else if (at_end)
                begin
                    strobe_next     = 1'b1;
                    kind_next       = ptp_pkg::KIND_FAILED;
                    slot_index_next = '0;
                    last_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    cnt_next = rd_nxt;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold sequencer state and registered results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            last_tick_reg  <= '0;
            pend_vld_reg   <= 1'b0;
            fire_cnt_reg   <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            last_tick_reg  <= last_tick_next;
            pend_vld_reg   <= pend_vld_next;
            fire_cnt_reg   <= fire_cnt_next;
            strobe_reg     <= strobe_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        diff_reg       <= diff_next;
        ivl_reg        <= ivl_next;
        pend_idx_reg   <= pend_idx_next;
        kind_reg       <= kind_next;
        slot_index_reg <= slot_index_next;
        last_reg       <= last_next;
    end

    assign result_strobe = strobe_reg;
    assign kind          = kind_reg;
    assign slot_index    = slot_index_reg;
    assign last          = last_reg;

    // Results only follow a cycle of sequencer activity
    `PTP_ASSERT_NEXT(a_no_result_when_idle, !busy, !result_strobe, "result while idle")
    // Create results are single and therefore final
    `PTP_ASSERT(a_create_last, !result_strobe || (kind == ptp_pkg::KIND_FIRED) || last, "create result not last")
    // A failed create reports slot zero
    `PTP_ASSERT(a_fail_zero, !result_strobe || (kind != ptp_pkg::KIND_FAILED) || (slot_index == '0), "fail with slot")
    // Reported fires stay within the result limit
    `PTP_ASSERT(a_fire_limit, fire_cnt_reg <= ptp_pkg::FIRE_W'(ptp_pkg::MAX_RESULTS), "fire count overflow")
    // No held fire survives into idle
    `PTP_ASSERT(a_pend_idle, (state_reg != ST_IDLE) || !pend_vld_reg, "held fire while idle")

endmodule
